// ===== sv/gbn_pkg.sv =====
// Shared package for the go-back-n sender window block.
// Holds protocol constants, header kinds, action codes and the controller/datapath bundles.
package gbn_pkg;

  localparam int unsigned MAX_WINDOW_PACKETS = 63;
  localparam int CNT_W = $clog2(MAX_WINDOW_PACKETS + 1);

  localparam logic [32:0] SEQ_SPACE = 33'd4294967000;
  localparam logic [9:0]  SEQ_STEP  = 10'd1000;
  localparam logic [9:0]  PAY_MAX   = 10'd991;
  localparam logic [3:0]  HDR_LEN   = 4'd9;

  // ceil(2^36 / 125): (d >> 3) * STEP_RECIP >> 36 gives d / 1000 exactly for 32-bit d
  localparam logic [29:0] STEP_RECIP = 30'd549755814;

  localparam logic [15:0] WINDOW_RST  = 16'd4000;
  localparam logic [15:0] TIMEOUT_RST = 16'd3;

  // action codes
  localparam logic [1:0] ACT_REQ  = 2'd0;
  localparam logic [1:0] ACT_ACK  = 2'd1;
  localparam logic [1:0] ACT_TICK = 2'd2;

  // header kinds
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_ERR  = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // configuration register indexes
  localparam logic REG_WINDOW  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic load_req;
    logic err;
    logic load_ack;
    logic ack_base;
    logic div_step;
    logic ack_mul;
    logic ack_sum;
    logic tick_dec;
    logic rewind;
    logic send;
    logic complete;
    logic flush;
    logic set_halt;
  } gbn_cmd_t;

  typedef struct packed {
    logic can_send;
    logic pend_v;
    logic out_free;
    logic halted;
    logic enabled;
    logic armed;
    logic tick_gt1;
    logic finished;
  } gbn_stat_t;

endpackage

// ===== sv/gbn_ctrl.sv =====
// Controller state machine for the go-back-n sender window.
// Depends on gbn_pkg; drives the datapath through gbn_cmd_t only.
module gbn_ctrl import gbn_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  input  logic       in_file_found,
  output logic       in_stall,
  input  gbn_stat_t  stat,
  output gbn_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BASE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SUM   = 3'd4;
  localparam logic [2:0] S_SEND  = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_WINDOW_PACKETS);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             slot;

  assign in_stall = (state_r != S_IDLE);
  assign slot     = !stat.pend_v || stat.out_free;

  // sequence one input word through its steps
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !stat.halted) begin
          case (in_action)
            ACT_REQ: begin
              if (!stat.enabled) begin
                if (in_file_found) begin
                  cmd.load_req = 1'b1;
                  cnt_nxt      = '0;
                  state_nxt    = S_SEND;
                end else begin
                  cmd.err      = 1'b1;
                  cmd.set_halt = 1'b1;
                  state_nxt    = S_FLUSH;
                end
              end
            end
            ACT_ACK: begin
              if (stat.enabled) begin
                cmd.load_ack = 1'b1;
                state_nxt    = S_BASE;
              end
            end
            ACT_TICK: begin
              if (stat.armed) begin
                if (stat.tick_gt1) begin
                  cmd.tick_dec = 1'b1;
                end else begin
                  cmd.rewind = 1'b1;
                  cnt_nxt    = '0;
                  state_nxt  = S_SEND;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_BASE: begin
        cmd.ack_base = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_MUL;
      end
      S_MUL: begin
        cmd.ack_mul = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.ack_sum = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = S_SEND;
      end
      S_SEND: begin
        if (stat.can_send && cnt_r != CNT_MAX) begin
          if (slot) begin
            cmd.send = 1'b1;
            cnt_nxt  = cnt_r + 1'b1;
          end
        end else if (stat.finished) begin
          if (slot) begin
            cmd.complete = 1'b1;
            cmd.set_halt = 1'b1;
            state_nxt    = S_FLUSH;
          end
        end else begin
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!stat.pend_v) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== sv/gbn_dp.sv =====
// Datapath for the go-back-n sender window: window state, timer, divider and header registers.
// Depends on gbn_pkg; obeys gbn_cmd_t from the controller and reports gbn_stat_t.
module gbn_dp import gbn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  gbn_cmd_t    cmd,
  output gbn_stat_t   stat,
  input  logic [31:0] in_file_size,
  input  logic [31:0] in_ack_number,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [31:0] out_seq_number,
  output logic [9:0]  out_payload_bytes,
  output logic [31:0] out_file_offset,
  output logic        out_last_packet,
  output logic        out_last
);

  logic [15:0] window_r, timeout_r;
  logic [31:0] base_r, next_r, acked_r, sent_r, size_r, ack_r;
  logic        enabled_r, all_sent_r, armed_r, halted_r, finished_r;
  logic [15:0] timer_r;
  logic [31:0] dq_r;
  logic [31:0] prod_r;

  // pending header, held until the next decision tells whether it is last
  logic        pend_v_r;
  logic [1:0]  pend_kind_r;
  logic [31:0] pend_seq_r, pend_off_r;
  logic [9:0]  pend_pay_r;
  logic        pend_lastp_r;

  logic        out_v_r;
  logic        out_free;
  logic [15:0] arm_val;
  logic [32:0] sdist, ack_t, nb_full, adist, ns_sum, sum;
  logic [31:0] new_base, rem_bytes, ns_mod;
  logic [9:0]  pay;
  logic        lastp;
  logic [58:0] recip_p;
  logic        push;

  assign out_free = !out_v_r || !out_stall;
  assign arm_val  = (timeout_r == 16'd0) ? 16'd1 : timeout_r;

  // window distance from base to next sequence
  always_comb begin
    if (next_r >= base_r) sdist = {1'b0, next_r} - {1'b0, base_r};
    else                  sdist = {1'b0, next_r} + SEQ_SPACE - {1'b0, base_r};
  end

  // next data header
  assign rem_bytes = size_r - sent_r;
  assign pay       = (rem_bytes < {22'd0, PAY_MAX}) ? rem_bytes[9:0] : PAY_MAX;
  assign lastp     = (sent_r + {22'd0, pay}) == size_r;
  assign ns_sum    = {1'b0, next_r} + {29'd0, HDR_LEN} + {23'd0, pay};
  assign ns_mod    = (ns_sum >= SEQ_SPACE) ? 32'(ns_sum - SEQ_SPACE) : ns_sum[31:0];

  // new base from the acknowledgement
  assign ack_t    = {1'b0, ack_r} + {23'd0, SEQ_STEP};
  assign nb_full  = (ack_t >= SEQ_SPACE) ? (ack_t - SEQ_SPACE) : ack_t;
  assign new_base = nb_full[31:0];
  always_comb begin
    if (new_base >= base_r) adist = {1'b0, new_base} - {1'b0, base_r};
    else                    adist = {1'b0, new_base} + SEQ_SPACE - {1'b0, base_r};
  end

  // distance over 8, times the reciprocal of 125
  assign recip_p = {30'd0, dq_r[31:3]} * {29'd0, STEP_RECIP};
  assign sum     = {1'b0, acked_r} + {1'b0, prod_r};
  assign push    = (cmd.send || cmd.complete) && pend_v_r;

  assign stat.can_send = enabled_r && !all_sent_r && (sent_r < size_r) &&
                         (sdist + {23'd0, SEQ_STEP} <= {17'd0, window_r});
  assign stat.pend_v   = pend_v_r;
  assign stat.out_free = out_free;
  assign stat.halted   = halted_r;
  assign stat.enabled  = enabled_r;
  assign stat.armed    = armed_r;
  assign stat.tick_gt1 = timer_r > 16'd1;
  assign stat.finished = finished_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r  <= WINDOW_RST;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WINDOW) window_r  <= cfg_data;
      else                         timeout_r <= cfg_data;
    end
  end

  // window, timer and control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= '0;
      next_r     <= '0;
      acked_r    <= '0;
      sent_r     <= '0;
      size_r     <= '0;
      enabled_r  <= 1'b0;
      all_sent_r <= 1'b0;
      armed_r    <= 1'b0;
      timer_r    <= '0;
      halted_r   <= 1'b0;
      finished_r <= 1'b0;
    end else begin
      if (cmd.set_halt) halted_r <= 1'b1;
      if (cmd.load_req) begin
        size_r     <= in_file_size;
        enabled_r  <= 1'b1;
        finished_r <= 1'b0;
      end
      if (cmd.ack_base) base_r <= new_base;
      if (cmd.ack_sum) begin
        acked_r    <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        finished_r <= (sum[32] ? 32'hFFFF_FFFF : sum[31:0]) >= size_r;
        if (base_r == next_r) begin
          armed_r <= 1'b0;
          timer_r <= '0;
        end else begin
          armed_r <= 1'b1;
          timer_r <= arm_val;
        end
      end
      if (cmd.tick_dec) timer_r <= timer_r - 16'd1;
      if (cmd.rewind) begin
        armed_r    <= 1'b1;
        timer_r    <= arm_val;
        all_sent_r <= 1'b0;
        sent_r     <= acked_r;
        next_r     <= base_r;
        finished_r <= 1'b0;
      end
      if (cmd.send) begin
        if (lastp) all_sent_r <= 1'b1;
        if (base_r == next_r) begin
          armed_r <= 1'b1;
          timer_r <= arm_val;
        end
        next_r <= ns_mod;
        sent_r <= sent_r + {22'd0, pay};
      end
    end
  end

  // acknowledgement count: divide distance by the step, then scale to payload bytes
  always_ff @(posedge clk) begin
    if (cmd.load_ack) ack_r <= in_ack_number;
    if (cmd.ack_base) begin
      dq_r <= adist[31:0];
    end else if (cmd.div_step) begin
      dq_r <= {9'd0, recip_p[58:36]};
    end
    if (cmd.ack_mul) prod_r <= {9'd0, dq_r[22:0]} * {22'd0, PAY_MAX};
  end

  // pending header
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.send || cmd.complete || cmd.err) begin
      pend_v_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      pend_kind_r  <= KIND_DATA;
      pend_seq_r   <= next_r;
      pend_pay_r   <= pay;
      pend_off_r   <= sent_r;
      pend_lastp_r <= lastp;
    end else if (cmd.complete) begin
      pend_kind_r  <= KIND_DONE;
      pend_seq_r   <= next_r;
      pend_pay_r   <= '0;
      pend_off_r   <= sent_r;
      pend_lastp_r <= 1'b0;
    end else if (cmd.err) begin
      pend_kind_r  <= KIND_ERR;
      pend_seq_r   <= '0;
      pend_pay_r   <= '0;
      pend_off_r   <= '0;
      pend_lastp_r <= 1'b0;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (push || cmd.flush) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push || cmd.flush) begin
      out_kind          <= pend_kind_r;
      out_seq_number    <= pend_seq_r;
      out_payload_bytes <= pend_pay_r;
      out_file_offset   <= pend_off_r;
      out_last_packet   <= pend_lastp_r;
      out_last          <= cmd.flush;
    end
  end

  assign out_valid = out_v_r;

endmodule

// ===== sv/go_back_n_sender_window_top.sv =====
// Go-back-n sender window. A word on the input channel is a file request, a cumulative
// acknowledgement or a timer tick; the block answers with zero or more header words, the
// final one flagged by out_last. A request or a timeout tick holds the input stalled while
// the block sends its headers, then finds the window closed or sends the completion
// header, then hands over the last header; an acknowledgement first updates the base,
// divides the base movement by the step through a reciprocal multiply, scales it to
// payload bytes and adds it up. A tick that only counts down and an ignored word do not
// stall the input. Up to 63 data headers go out per input word, at most one a cycle while
// the output is not stalled; the input stalls until the last header of a word has been
// handed to the output register. After a completion or an error header the block ignores
// all further input.
// Depends on gbn_pkg, gbn_ctrl and gbn_dp.
module go_back_n_sender_window_top import gbn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic        in_file_found,
  input  logic [31:0] in_file_size,
  input  logic [31:0] in_ack_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [31:0] out_seq_number,
  output logic [9:0]  out_payload_bytes,
  output logic [31:0] out_file_offset,
  output logic        out_last_packet,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  gbn_cmd_t  cmd;
  gbn_stat_t stat;

  assign cfg_ready = 1'b1;

  gbn_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_action     (in_action),
    .in_file_found (in_file_found),
    .in_stall      (in_stall),
    .stat          (stat),
    .cmd           (cmd)
  );

  gbn_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_file_size      (in_file_size),
    .in_ack_number     (in_ack_number),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_seq_number    (out_seq_number),
    .out_payload_bytes (out_payload_bytes),
    .out_file_offset   (out_file_offset),
    .out_last_packet   (out_last_packet),
    .out_last          (out_last)
  );

endmodule

// ===== sv/gbn_check.sv =====
// Port-level checker for the go-back-n sender window, bound to the top level.
// Depends on gbn_pkg for header kinds.
module gbn_check import gbn_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [31:0] out_seq_number,
  input logic [9:0]  out_payload_bytes,
  input logic        out_last_packet,
  input logic        out_last
);

  // hold a stalled output word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_seq_number) && $stable(out_kind))
    else $error("stalled output word changed");

  // error header closes its word and carries nothing
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_last && out_seq_number == 32'd0 &&
    out_payload_bytes == 10'd0)
    else $error("malformed error header");

  // completion header is last and empty
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DONE |-> out_last && out_payload_bytes == 10'd0 &&
    !out_last_packet)
    else $error("malformed completion header");

  // data payload stays within a packet
  a_pay: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_payload_bytes <= PAY_MAX)
    else $error("data payload too long");

endmodule

bind go_back_n_sender_window_top gbn_check u_gbn_check (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_kind          (out_kind),
  .out_seq_number    (out_seq_number),
  .out_payload_bytes (out_payload_bytes),
  .out_last_packet   (out_last_packet),
  .out_last          (out_last)
);

// ===== tb/sv/tb_go_back_n_sender_window_top.sv =====
// Self-checking bench for the go-back-n sender window: a scoreboard class predicts header words,
// plain tasks drive requests, acknowledgements, ticks and register writes.
// Depends on gbn_pkg and go_back_n_sender_window_top.
module tb_go_back_n_sender_window_top;
  import gbn_pkg::*;

  localparam longint unsigned SPACE = 64'd4294967000;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] seq;
    logic [9:0]  pay;
    logic [31:0] off;
    logic        last_pkt;
    logic        last;
  } hdr_t;

  class gbn_scoreboard;
    hdr_t        pending[$];
    int          errors;
    logic [15:0] win, tmo, tcount;
    logic [31:0] base, nxt, acked, sent_off, fsize;
    bit          enabled, all_sent, armed, halted;

    function new();
      errors = 0;
      win = WINDOW_RST;
      tmo = TIMEOUT_RST;
      tcount = 0;
      base = 0; nxt = 0; acked = 0; sent_off = 0; fsize = 0;
      enabled = 0; all_sent = 0; armed = 0; halted = 0;
    endfunction

    function void set_reg(logic idx, logic [15:0] val);
      if (idx == REG_WINDOW) win = val;
      else tmo = val;
    endfunction

    function void arm();
      armed = 1;
      tcount = (tmo != 0) ? tmo : 16'd1;
    endfunction

    function void push(logic [1:0] k, logic [31:0] s, logic [9:0] p, logic [31:0] o,
                       logic lp);
      hdr_t h;
      h.kind = k; h.seq = s; h.pay = p; h.off = o; h.last_pkt = lp; h.last = 0;
      pending.push_back(h);
    endfunction

    // emit data headers while the window has room, at most MAX_WINDOW_PACKETS per word
    function void fill_window();
      int cnt;
      longint unsigned span;
      logic [31:0] rem, pay;
      logic lp;
      cnt = 0;
      while (enabled && !all_sent && cnt < MAX_WINDOW_PACKETS && sent_off < fsize) begin
        span = (longint'(nxt) + SPACE - longint'(base)) % SPACE;
        if (span + 1000 > longint'(win)) break;
        rem = fsize - sent_off;
        pay = (rem < 991) ? rem : 32'd991;
        lp = (sent_off + pay == fsize);
        push(KIND_DATA, nxt, pay[9:0], sent_off, lp);
        cnt++;
        if (lp) all_sent = 1;
        if (base == nxt) arm();
        nxt = 32'((longint'(nxt) + 9 + longint'(pay)) % SPACE);
        sent_off = sent_off + pay;
      end
    endfunction

    // predict the headers caused by one accepted input word
    function void note_input(logic [1:0] act, logic found, logic [31:0] size,
                             logic [31:0] ackn);
      int start;
      bit finished;
      longint unsigned nb, span, sum;
      start = pending.size();
      finished = 0;
      if (halted) return;
      case (act)
        ACT_REQ: begin
          if (enabled) return;
          if (!found) begin
            push(KIND_ERR, 0, 0, 0, 0);
            halted = 1;
          end else begin
            fsize = size;
            enabled = 1;
            fill_window();
          end
        end
        ACT_ACK: begin
          if (!enabled) return;
          nb = (longint'(ackn) + 1000) % SPACE;
          span = (nb + SPACE - longint'(base)) % SPACE;
          sum = longint'(acked) + (span / 1000) * 991;
          acked = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(sum);
          finished = (acked >= fsize);
          base = 32'(nb);
          if (base == nxt) begin
            armed = 0;
            tcount = 0;
          end else begin
            arm();
          end
          fill_window();
        end
        ACT_TICK: begin
          if (!armed) return;
          if (tcount > 1) begin
            tcount--;
            return;
          end
          arm();
          all_sent = 0;
          sent_off = acked;
          nxt = base;
          fill_window();
        end
        default: return;
      endcase
      if (finished) begin
        push(KIND_DONE, nxt, 0, sent_off, 0);
        halted = 1;
      end
      if (pending.size() > start) pending[$].last = 1;
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check(hdr_t got);
      hdr_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected header kind=%0d seq=%0d", got.kind, got.seq));
        return;
      end
      want = pending.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d", got.kind, want.kind));
      if (got.seq !== want.seq)
        report($sformatf("seq_number %0d, want %0d", got.seq, want.seq));
      if (got.pay !== want.pay)
        report($sformatf("payload_bytes %0d, want %0d", got.pay, want.pay));
      if (got.off !== want.off)
        report($sformatf("file_offset %0d, want %0d", got.off, want.off));
      if (got.last_pkt !== want.last_pkt)
        report($sformatf("last_packet %0b, want %0b", got.last_pkt, want.last_pkt));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_file_found;
  logic [1:0]  in_action;
  logic [31:0] in_file_size, in_ack_number;
  logic        out_valid, out_stall, out_last_packet, out_last;
  logic [1:0]  out_kind;
  logic [31:0] out_seq_number, out_file_offset;
  logic [9:0]  out_payload_bytes;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;

  gbn_scoreboard sb;
  bit hold_req;
  int hold_cnt, stall_mode, cyc, idle_cnt;

  go_back_n_sender_window_top dut (.*);

  initial clk = 0;
  always #5 clk = ~clk;

  // receiver: stall pattern redrawn from three modes, long hold-off on request
  always @(posedge clk) begin
    cyc++;
    if (!rst_n) begin
      out_stall <= 0;
    end else if (hold_req || hold_cnt > 0) begin
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = 400;
      end
      hold_cnt--;
      out_stall <= 1;
    end else begin
      if (cyc % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // check every accepted header word
  always @(posedge clk) begin
    hdr_t h;
    if (rst_n && out_valid && !out_stall) begin
      h.kind = out_kind; h.seq = out_seq_number; h.pay = out_payload_bytes;
      h.off = out_file_offset; h.last_pkt = out_last_packet; h.last = out_last;
      sb.check(h);
    end
  end

  // end the run when no handshake completes for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cnt = 0;
    else
      idle_cnt++;
    if (idle_cnt >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("** go_back_n_sender_window_top: FAILED **");
      $finish;
    end
  end

  task send_word(logic [1:0] act, logic found, logic [31:0] size, logic [31:0] ackn);
    in_valid      <= 1;
    in_action     <= act;
    in_file_found <= found;
    in_file_size  <= size;
    in_ack_number <= ackn;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(act, found, size, ackn);
  endtask

  task write_reg(logic idx, logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  // hold the sender until every expected header has come, then let the block settle
  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task random_junk();
    send_word($urandom_range(0, 1) ? ACT_REQ : 2'd3, $urandom_range(0, 1), $urandom,
              $urandom);
  endtask

  // acknowledge a random number of outstanding packets, or repeat the base
  task good_ack();
    longint unsigned outst, k, a;
    outst = ((longint'(sb.nxt) + SPACE - longint'(sb.base)) % SPACE) / 1000;
    k = (outst > 0) ? $urandom_range(1, 32'(outst)) : 0;
    a = (longint'(sb.base) + SPACE + k * 1000 - 1000) % SPACE;
    send_word(ACT_ACK, $urandom_range(0, 1), $urandom, 32'(a));
  endtask

  task new_phase();
    logic [15:0] w, t;
    drain();
    case ($urandom_range(0, 3))
      0: w = 16'd1000;
      1: w = 16'd63000;
      default: w = 16'($urandom_range(1000, 63000));
    endcase
    case ($urandom_range(0, 5))
      0: t = 16'd1;
      1: t = 16'd65535;
      2: t = 16'd0;
      default: t = 16'($urandom_range(1, 6));
    endcase
    write_reg(REG_WINDOW, w);
    write_reg(REG_TIMEOUT, t);
  endtask

  initial begin
    int i, r, n;
    bit gaps;
    sb = new();
    rst_n = 0;
    in_valid = 0; in_action = ACT_REQ; in_file_found = 0;
    in_file_size = 0; in_ack_number = 0;
    out_stall = 0;
    cfg_valid = 0; cfg_index = REG_WINDOW; cfg_data = 0;
    hold_req = 0; hold_cnt = 0; stall_mode = 0; cyc = 0; idle_cnt = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: ignored words before any request, then a narrow window
    send_word(ACT_TICK, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ACT_ACK, 1, 0, 0);
    send_word(2'd3, 1, 32'hFFFF_FFFF, 32'd4294966999);
    drain();
    write_reg(REG_WINDOW, 16'd1000);
    write_reg(REG_TIMEOUT, 16'd1);
    send_word(ACT_REQ, 1, 32'hFFFF_FFFF, 0);
    send_word(ACT_TICK, 0, 0, 0);
    send_word(ACT_ACK, 0, 0, 32'd0);
    send_word(ACT_REQ, 0, 0, 0);
    send_word(ACT_TICK, 0, 0, 0);
    drain();
    write_reg(REG_WINDOW, 16'd63000);
    write_reg(REG_TIMEOUT, 16'd0);
    send_word(ACT_TICK, 0, 0, 0);
    good_ack();
    good_ack();
    send_word(ACT_TICK, 0, 0, 0);
    good_ack();

    // random: mostly in-window acknowledgements and ticks, some noise
    gaps = 1;
    for (i = 0; i < 320; i++) begin
      if (i % 40 == 39) begin
        new_phase();
        gaps = $urandom_range(0, 1);
      end
      if (i == 120) hold_req = 1;
      r = $urandom_range(0, 99);
      if (r < 55) good_ack();
      else if (r < 90) send_word(ACT_TICK, $urandom_range(0, 1), $urandom, $urandom);
      else random_junk();
      if (gaps && $urandom_range(0, 3) == 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end

    // close out: stale and extreme acknowledgements until the transfer completes or 20 random ones have gone
    drain();
    send_word(ACT_ACK, 0, 0, 32'd4294966999);
    n = 0;
    while (!sb.halted && n < 20) begin
      send_word(ACT_ACK, 1, 0, 32'(longint'({$urandom, $urandom}) % SPACE));
      n++;
    end
    send_word(ACT_REQ, 0, 0, 0);
    send_word(ACT_TICK, 0, 0, 0);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("** go_back_n_sender_window_top: PASSED **");
    end else begin
      $display("** go_back_n_sender_window_top: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/gbn_pkg.sv
sv/gbn_ctrl.sv
sv/gbn_dp.sv
sv/go_back_n_sender_window_top.sv
sv/gbn_check.sv
tb/sv/tb_go_back_n_sender_window_top.sv
